FILE: hw/rtl/mp2d_pkg.sv
// ----------------------------------------------------------------------------
// mp2d_pkg
// Shared constants and types of the streaming 2-D max pooling block.
// ----------------------------------------------------------------------------
package mp2d_pkg;

  // Parameter defaults
  localparam int unsigned MAX_WIDTH_DEF   = 256;
  localparam int unsigned MAX_POOL_DEF    = 4;
  localparam int unsigned SAMPLE_BITS_DEF = 32;

  // Fixed field widths
  localparam int unsigned HEIGHT_W   = 9;
  localparam int unsigned WIDTH_W    = 9;
  localparam int unsigned POOL_REG_W = 3;
  localparam int unsigned STEP_W     = 3;
  localparam int unsigned PLANE_W    = 16;
  localparam int unsigned ROW_W      = 8;
  localparam int unsigned NEXT_ROW_W = 10;
  localparam int unsigned HEIGHT_MAX = 256;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_IN_HEIGHT   = 3'd0,
    CFG_IN_WIDTH    = 3'd1,
    CFG_POOL_HEIGHT = 3'd2,
    CFG_POOL_WIDTH  = 3'd3,
    CFG_STEP_ROWS   = 3'd4,
    CFG_STEP_COLS   = 3'd5,
    CFG_PLANE_COUNT = 3'd6
  } cfg_idx_e;

  // Register reset values
  localparam logic [HEIGHT_W-1:0]   RST_IN_HEIGHT   = 9'd8;
  localparam logic [WIDTH_W-1:0]    RST_IN_WIDTH    = 9'd8;
  localparam logic [POOL_REG_W-1:0] RST_POOL_HEIGHT = 3'd2;
  localparam logic [POOL_REG_W-1:0] RST_POOL_WIDTH  = 3'd2;
  localparam logic [STEP_W-1:0]     RST_STEP_ROWS   = 3'd2;
  localparam logic [STEP_W-1:0]     RST_STEP_COLS   = 3'd2;
  localparam logic [PLANE_W-1:0]    RST_PLANE_COUNT = 16'd1;

endpackage

FILE: hw/rtl/mp2d_if.sv
// ----------------------------------------------------------------------------
// mp2d stream interfaces
// Valid/ready channels for input samples and pooled results.
// ----------------------------------------------------------------------------
interface mp2d_in_if #(
  parameter int unsigned SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface mp2d_out_if #(
  parameter int unsigned SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] pooled;
  logic                   plane_done;
  logic                   job_done;

  modport source (output valid, output pooled, output plane_done, output job_done,
                  input ready);
  modport sink   (input valid, input pooled, input plane_done, input job_done,
                  output ready);
endinterface

FILE: hw/rtl/max_pool_2d_stream_core.sv
// ----------------------------------------------------------------------------
// max_pool_2d_stream_core
// Streaming 2-D max pooling over raster-ordered planes of signed samples.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch takes one sample per item, row by row, plane after plane.
//   out_ch gives one pooled item when the bottom-right sample of a window
//   arrives; plane_done / job_done flag the last window of a plane / job.
//   Samples no window ends on produce no output item.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the geometry registers; any write
//   to one of them restarts the job at row 0, column 0, plane 0. Write only while idle.
// Timing:
//   One item per cycle while out_ch takes results. A result passes the
//   input/read stage, the column-max stage and the output register after
//   its sample is accepted. The line store is MAX_POOL-1 banks, one per stored
//   row, all read once per item at the current column; only the current row's bank is written.
// Reset and stalls:
//   Reset restores the register defaults and empties the pipeline; line
//   store contents are not cleared. When out_ch stalls, the pipeline keeps
//   taking items until its stages are full, then drops in_ch.ready.
// ----------------------------------------------------------------------------
module max_pool_2d_stream_core #(
  parameter int unsigned MAX_WIDTH   = mp2d_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_POOL    = mp2d_pkg::MAX_POOL_DEF,
  parameter int unsigned SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mp2d_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [mp2d_pkg::CFG_DATA_W-1:0] cfg_data_i,
  mp2d_in_if.sink                         in_ch,
  mp2d_out_if.source                      out_ch
);

  localparam int unsigned HistDepth = MAX_POOL - 1;
  localparam int unsigned BankW     = (HistDepth > 1) ? $clog2(HistDepth) : 1;
  localparam int unsigned ColW      = $clog2(MAX_WIDTH);
  localparam int unsigned NcW       = $clog2(MAX_WIDTH + 32);
  localparam int unsigned PoolW     = $clog2(MAX_POOL + 1);
  localparam int unsigned NrW       = mp2d_pkg::NEXT_ROW_W;
  localparam int unsigned RowW      = mp2d_pkg::ROW_W;

  // configuration registers
  logic [mp2d_pkg::HEIGHT_W-1:0]   h_reg_q;
  logic [mp2d_pkg::WIDTH_W-1:0]    w_reg_q;
  logic [mp2d_pkg::POOL_REG_W-1:0] ph_reg_q, pw_reg_q;
  logic [mp2d_pkg::STEP_W-1:0]     sr_reg_q, sc_reg_q;
  logic [mp2d_pkg::PLANE_W-1:0]    np_reg_q;
  logic                            cfg_hit;

  // effective (clamped) geometry
  logic [mp2d_pkg::HEIGHT_W-1:0] h_eff;
  logic [NcW-1:0]                w_eff;
  logic [PoolW-1:0]              ph_eff, pw_eff;
  logic [mp2d_pkg::STEP_W-1:0]   sr_eff, sc_eff;
  logic [mp2d_pkg::PLANE_W-1:0]  np_eff;

  // position counters
  logic [RowW-1:0]              r_q;
  logic [ColW-1:0]              c_q;
  logic [mp2d_pkg::PLANE_W-1:0] pl_q;
  logic [BankW-1:0]             rb_q;
  logic [NrW-1:0]               nr_q, nr_eff;
  logic [NcW-1:0]               nc_q, nc_eff;

  logic acc;
  logic row_hit, col_hit, row_end, plane_end, row_ok;
  logic emit, pdone, jdone;
  logic [HistDepth-1:0] bank_mask;

  // pipeline
  logic                   s1_v_q, s1_emit_q, s1_pdone_q, s1_jdone_q;
  logic [SAMPLE_BITS-1:0] s1_x_q;
  logic [HistDepth-1:0]   s1_mask_q;
  logic [SAMPLE_BITS-1:0] bank_rd [HistDepth];
  logic [SAMPLE_BITS-1:0] colmax;

  logic                   s2_v_q, s2_emit_q, s2_pdone_q, s2_jdone_q;
  logic [SAMPLE_BITS-1:0] s2_cm_q;
  logic [SAMPLE_BITS-1:0] hist_q [HistDepth];
  logic [SAMPLE_BITS-1:0] win_max;

  logic                   out_v_q, out_pd_q, out_jd_q;
  logic [SAMPLE_BITS-1:0] out_pooled_q;

  logic out_free, s2_adv, s2_free, s1_adv, s1_free;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_comb begin
    case (mp2d_pkg::cfg_idx_e'(cfg_idx_i))
      mp2d_pkg::CFG_IN_HEIGHT,
      mp2d_pkg::CFG_IN_WIDTH,
      mp2d_pkg::CFG_POOL_HEIGHT,
      mp2d_pkg::CFG_POOL_WIDTH,
      mp2d_pkg::CFG_STEP_ROWS,
      mp2d_pkg::CFG_STEP_COLS,
      mp2d_pkg::CFG_PLANE_COUNT: cfg_hit = cfg_we_i;
      default:                   cfg_hit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_reg_q  <= mp2d_pkg::RST_IN_HEIGHT;
      w_reg_q  <= mp2d_pkg::RST_IN_WIDTH;
      ph_reg_q <= mp2d_pkg::RST_POOL_HEIGHT;
      pw_reg_q <= mp2d_pkg::RST_POOL_WIDTH;
      sr_reg_q <= mp2d_pkg::RST_STEP_ROWS;
      sc_reg_q <= mp2d_pkg::RST_STEP_COLS;
      np_reg_q <= mp2d_pkg::RST_PLANE_COUNT;
    end else if (cfg_we_i) begin
      case (mp2d_pkg::cfg_idx_e'(cfg_idx_i))
        mp2d_pkg::CFG_IN_HEIGHT:   h_reg_q  <= cfg_data_i[mp2d_pkg::HEIGHT_W-1:0];
        mp2d_pkg::CFG_IN_WIDTH:    w_reg_q  <= cfg_data_i[mp2d_pkg::WIDTH_W-1:0];
        mp2d_pkg::CFG_POOL_HEIGHT: ph_reg_q <= cfg_data_i[mp2d_pkg::POOL_REG_W-1:0];
        mp2d_pkg::CFG_POOL_WIDTH:  pw_reg_q <= cfg_data_i[mp2d_pkg::POOL_REG_W-1:0];
        mp2d_pkg::CFG_STEP_ROWS:   sr_reg_q <= cfg_data_i[mp2d_pkg::STEP_W-1:0];
        mp2d_pkg::CFG_STEP_COLS:   sc_reg_q <= cfg_data_i[mp2d_pkg::STEP_W-1:0];
        mp2d_pkg::CFG_PLANE_COUNT: np_reg_q <= cfg_data_i[mp2d_pkg::PLANE_W-1:0];
        default: ;
      endcase
    end
  end

  // zero acts as one, oversized values saturate
  always_comb begin
    h_eff = (h_reg_q == '0) ? mp2d_pkg::HEIGHT_W'(1) :
            ((32'(h_reg_q) > mp2d_pkg::HEIGHT_MAX) ?
             mp2d_pkg::HEIGHT_W'(mp2d_pkg::HEIGHT_MAX) : h_reg_q);
    w_eff = (w_reg_q == '0) ? NcW'(1) :
            ((32'(w_reg_q) > MAX_WIDTH) ? NcW'(MAX_WIDTH) : NcW'(w_reg_q));
    ph_eff = (ph_reg_q == '0) ? PoolW'(1) :
             ((32'(ph_reg_q) > MAX_POOL) ? PoolW'(MAX_POOL) : PoolW'(ph_reg_q));
    pw_eff = (pw_reg_q == '0) ? PoolW'(1) :
             ((32'(pw_reg_q) > MAX_POOL) ? PoolW'(MAX_POOL) : PoolW'(pw_reg_q));
    sr_eff = (sr_reg_q == '0) ? mp2d_pkg::STEP_W'(1) : sr_reg_q;
    sc_eff = (sc_reg_q == '0) ? mp2d_pkg::STEP_W'(1) : sc_reg_q;
    np_eff = (np_reg_q == '0) ? mp2d_pkg::PLANE_W'(1) : np_reg_q;
  end

  // --------------------------------------------------------------------------
  // position tracking and window decode
  // --------------------------------------------------------------------------
  assign acc = in_ch.valid && in_ch.ready;

  always_comb begin
    // next window bottom row / right column; recomputed at row / column 0
    nr_eff    = (r_q == '0) ? (NrW'(ph_eff) - NrW'(1)) : nr_q;
    nc_eff    = (c_q == '0) ? (NcW'(pw_eff) - NcW'(1)) : nc_q;
    row_hit   = (NrW'(r_q) == nr_eff);
    col_hit   = (NcW'(c_q) == nc_eff);
    row_end   = (NcW'(c_q) == (w_eff - NcW'(1)));
    plane_end = row_end && (NrW'(r_q) == (NrW'(h_eff) - NrW'(1)));
    row_ok    = (NrW'(r_q) + NrW'(1)) >= NrW'(ph_eff);
    emit      = row_hit && col_hit;
    // last window of the plane: no further window fits below or to the right
    pdone     = emit && ((nr_eff + NrW'(sr_eff)) >= NrW'(h_eff)) &&
                ((nc_eff + NcW'(sc_eff)) >= w_eff);
    jdone     = pdone && (pl_q == (np_eff - mp2d_pkg::PLANE_W'(1)));
  end

  // bank b holds row r-k; include it when k < pool height
  always_comb begin
    logic [PoolW-1:0] k;
    for (int b = 0; b < HistDepth; b++) begin
      if (rb_q > BankW'(b)) begin
        k = PoolW'(rb_q) - PoolW'(b);
      end else begin
        k = PoolW'(rb_q) + PoolW'(HistDepth) - PoolW'(b);
      end
      bank_mask[b] = row_ok && (k < ph_eff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_q  <= '0;
      c_q  <= '0;
      pl_q <= '0;
      rb_q <= '0;
      nr_q <= '0;
      nc_q <= '0;
    end else if (cfg_hit) begin
      r_q  <= '0;
      c_q  <= '0;
      pl_q <= '0;
      rb_q <= '0;
    end else if (acc) begin
      nc_q <= col_hit ? (nc_eff + NcW'(sc_eff)) : nc_eff;
      if (row_end) begin
        c_q  <= '0;
        nr_q <= row_hit ? (nr_eff + NrW'(sr_eff)) : nr_eff;
        if (plane_end) begin
          r_q  <= '0;
          rb_q <= '0;
          pl_q <= (pl_q == (np_eff - mp2d_pkg::PLANE_W'(1))) ? '0 :
                  (pl_q + mp2d_pkg::PLANE_W'(1));
        end else begin
          r_q  <= r_q + RowW'(1);
          rb_q <= (rb_q == BankW'(HistDepth - 1)) ? '0 : (rb_q + BankW'(1));
        end
      end else begin
        c_q <= c_q + ColW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // line store: one bank per stored row, read before write at column c
  // --------------------------------------------------------------------------
  for (genvar b = 0; b < HistDepth; b++) begin : gen_bank
    logic [SAMPLE_BITS-1:0] bank_mem [MAX_WIDTH];
    logic [SAMPLE_BITS-1:0] rd_q;

    always_ff @(posedge clk_i) begin
      if (acc) begin
        if (rb_q == BankW'(b)) begin
          bank_mem[c_q] <= in_ch.sample;
        end
        rd_q <= bank_mem[c_q];
      end
    end

    assign bank_rd[b] = rd_q;
  end

  // --------------------------------------------------------------------------
  // handshake chain
  // --------------------------------------------------------------------------
  assign out_free    = !out_v_q || out_ch.ready;
  assign s2_adv      = s2_v_q && (!s2_emit_q || out_free);
  assign s2_free     = !s2_v_q || s2_adv;
  assign s1_adv      = s1_v_q && s2_free;
  assign s1_free     = !s1_v_q || s1_adv;
  assign in_ch.ready = s1_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (acc) begin
        s1_v_q <= 1'b1;
      end else if (s1_adv) begin
        s1_v_q <= 1'b0;
      end
      if (s1_adv) begin
        s2_v_q <= 1'b1;
      end else if (s2_adv) begin
        s2_v_q <= 1'b0;
      end
      if (s2_adv && s2_emit_q) begin
        out_v_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: column maximum over the stored rows
  // --------------------------------------------------------------------------
  always_comb begin
    colmax = s1_x_q;
    for (int b = 0; b < HistDepth; b++) begin
      if (s1_mask_q[b] && ($signed(bank_rd[b]) > $signed(colmax))) begin
        colmax = bank_rd[b];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_x_q     <= in_ch.sample;
      s1_mask_q  <= bank_mask;
      s1_emit_q  <= emit;
      s1_pdone_q <= pdone;
      s1_jdone_q <= jdone;
    end
    if (s1_adv) begin
      s2_cm_q    <= colmax;
      s2_emit_q  <= s1_emit_q;
      s2_pdone_q <= s1_pdone_q;
      s2_jdone_q <= s1_jdone_q;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: window maximum over recent column maxima
  // --------------------------------------------------------------------------
  // hist_q[j] holds the column max from j+1 items back
  always_comb begin
    win_max = s2_cm_q;
    for (int j = 0; j < HistDepth; j++) begin
      if ((PoolW'(j + 1) < pw_eff) && ($signed(hist_q[j]) > $signed(win_max))) begin
        win_max = hist_q[j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv) begin
      hist_q[0] <= s2_cm_q;
      for (int j = 1; j < HistDepth; j++) begin
        hist_q[j] <= hist_q[j-1];
      end
    end
    if (s2_adv && s2_emit_q) begin
      out_pooled_q <= win_max;
      out_pd_q     <= s2_pdone_q;
      out_jd_q     <= s2_jdone_q;
    end
  end

  assign out_ch.valid      = out_v_q;
  assign out_ch.pooled     = out_pooled_q;
  assign out_ch.plane_done = out_pd_q;
  assign out_ch.job_done   = out_jd_q;

endmodule

FILE: hw/rtl/mp2d_checker.sv
// ----------------------------------------------------------------------------
// mp2d_core_checker
// Port-level assertions for max_pool_2d_stream_core, attached by bind.
// ----------------------------------------------------------------------------
module mp2d_core_checker #(
  parameter int unsigned SAMPLE_BITS = mp2d_pkg::SAMPLE_BITS_DEF
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_i,
  input logic                   out_valid_i,
  input logic                   out_ready_i,
  input logic [SAMPLE_BITS-1:0] out_pooled_i,
  input logic                   out_plane_done_i,
  input logic                   out_job_done_i
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_pooled_i) && $stable(out_plane_done_i) &&
                                    $stable(out_job_done_i))
    else $error("result payload changed while stalled");

  // end of job is always end of a plane
  a_job_plane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_job_done_i |-> out_plane_done_i)
    else $error("job_done without plane_done");

  // with the output register empty the pipeline always drains, so input is open
  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty output");

endmodule

bind max_pool_2d_stream_core mp2d_core_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_mp2d_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_ch.valid),
  .in_ready_i       (in_ch.ready),
  .out_valid_i      (out_ch.valid),
  .out_ready_i      (out_ch.ready),
  .out_pooled_i     (out_ch.pooled),
  .out_plane_done_i (out_ch.plane_done),
  .out_job_done_i   (out_ch.job_done)
);
